>>> src/thermistor_divider_to_temperature_defines.svh
// Assertion macros shared by the thermistor divider block.
// Needs clk and rst_n in the scope of every module that uses them.
`ifndef THERMISTOR_DIVIDER_TO_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_DIVIDER_TO_TEMPERATURE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TDT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tdt check failed: always");

// Same-cycle implication.
`define TDT_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdt check failed: implies");

// Next-cycle implication.
`define TDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdt check failed: next");

`endif

>>> src/tdt_pkg.sv
// Package for the thermistor divider block: widths, NTC table, queue item, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package tdt_pkg;

    localparam int UV_W     = 23;
    localparam int MV_W     = 14;              // 8388 mV at most
    localparam int SER_W    = 16;
    localparam int PROD_W   = MV_W + SER_W;    // node_mv * series, table * diff
    localparam int TEMP_W   = 16;
    localparam int SLOT_W   = 5;
    localparam int MON_W    = 4;
    localparam int CHAN_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int FLAG_W   = 2;
    localparam int FRAC_W   = 8;

    localparam int MUX_PHASES_DEF = 8;
    localparam logic [SER_W-1:0] SERIES_RESET = 16'd10000;

    // floor(x / 1000) = (x * ceil(2^33 / 1000)) >> 33, exact for x < 2^23
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 33;
    localparam logic [RECIP_W-1:0] MV_RECIP = 24'd8589935;
    localparam int SCALE_W  = UV_W + RECIP_W;

    // NTC table, one entry per degree from -13 C
    localparam int NTC_ENTRIES = 94;
    localparam int IDX_W       = $clog2(NTC_ENTRIES);
    localparam int COLD_DEG    = -13;
    localparam logic [TEMP_W-1:0] IDX_OFFSET = TEMP_W'(1 - COLD_DEG);
    localparam logic [TEMP_W-1:0] TEMP_COLD  = TEMP_W'(COLD_DEG * 256);
    localparam logic [TEMP_W-1:0] TEMP_HOT   = TEMP_W'((NTC_ENTRIES - 1 + COLD_DEG) * 256);

    localparam logic [15:0] NTC_OHMS [NTC_ENTRIES] = '{
        16'd65091, 16'd61596, 16'd58310, 16'd55218, 16'd52308, 16'd49569, 16'd46989,
        16'd44559, 16'd42268, 16'd40108, 16'd38071, 16'd36150, 16'd34336, 16'd32624,
        16'd31007, 16'd29480, 16'd28036, 16'd26672, 16'd25381, 16'd24161, 16'd23006,
        16'd21912, 16'd20877, 16'd19897, 16'd18968, 16'd18088, 16'd17253, 16'd16462,
        16'd15711, 16'd14999, 16'd14323, 16'd13681, 16'd13072, 16'd12493, 16'd11943,
        16'd11420, 16'd10923, 16'd10450, 16'd10000, 16'd9572,  16'd9165,  16'd8777,
        16'd8408,  16'd8056,  16'd7721,  16'd7401,  16'd7097,  16'd6807,  16'd6530,
        16'd6266,  16'd6014,  16'd5773,  16'd5543,  16'd5324,  16'd5114,  16'd4914,
        16'd4723,  16'd4540,  16'd4365,  16'd4198,  16'd4038,  16'd3885,  16'd3739,
        16'd3599,  16'd3465,  16'd3336,  16'd3213,  16'd3095,  16'd2982,  16'd2874,
        16'd2770,  16'd2671,  16'd2575,  16'd2484,  16'd2396,  16'd2312,  16'd2231,
        16'd2153,  16'd2079,  16'd2007,  16'd1938,  16'd1872,  16'd1809,  16'd1748,
        16'd1689,  16'd1633,  16'd1578,  16'd1526,  16'd1476,  16'd1428,  16'd1381,
        16'd1336,  16'd1293,  16'd1252
    };

    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NTC_ENTRIES - 1);

    typedef enum logic [FLAG_W-1:0] {
        RANGE_IN   = 2'd0,
        RANGE_COLD = 2'd1,
        RANGE_HOT  = 2'd2
    } range_t;

    // Item handed from front to back
    typedef struct packed {
        logic [MV_W-1:0]    diff;      // ref_mv - node_mv, clamped at zero
        logic [PROD_W-1:0]  numer;     // node_mv * series resistance
        logic [SLOT_W-1:0]  slot;
        logic [MON_W-1:0]   monitor;
    } tdt_item_t;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REF,
        F_NODE,
        F_PREP
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_COLD,
        B_HOT,
        B_SEARCH,
        B_NUM,
        B_DEN,
        B_DIV,
        B_WRITE
    } back_state_t;

endpackage

>>> src/tdt_front.sv
// Front end: takes a divider sample, scales to millivolts, forms diff and numerator.
// Depends on tdt_pkg; feeds tdt_queue.
`timescale 1ns / 1ps

module tdt_front #(
    parameter int MUX_PHASES = tdt_pkg::MUX_PHASES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [tdt_pkg::UV_W-1:0]    ref_uv,
    input  logic [tdt_pkg::UV_W-1:0]    node_uv,
    input  logic [tdt_pkg::MON_W-1:0]   monitor_index,
    input  logic [tdt_pkg::CHAN_W-1:0]  channel_index,
    input  logic                        scan_end,
    input  logic                        cfg_valid,
    input  logic [tdt_pkg::SER_W-1:0]   cfg_data,
    output logic                        q_push,
    input  logic                        q_full,
    output tdt_pkg::tdt_item_t          q_item
);
    import tdt_pkg::*;

    front_state_t           state_reg, state_next;
    logic [UV_W-1:0]        ref_raw_reg, node_raw_reg;
    logic [MON_W-1:0]       mon_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [MV_W-1:0]        ref_mv_reg, node_mv_reg;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [SER_W-1:0]       series_reg;
    logic                   accept;
    logic [UV_W-1:0]        mul_in;
    logic [SCALE_W-1:0]     scaled;
    logic [MV_W-1:0]        mv;

    assign accept = push && !full;

    // one shared reciprocal multiplier for both voltages
    assign mul_in = (state_reg == F_REF) ? ref_raw_reg : node_raw_reg;
    assign scaled = SCALE_W'(mul_in) * SCALE_W'(MV_RECIP);
    assign mv     = scaled[RECIP_SH +: MV_W];

    assign phase_next = (phase_reg == PHASE_W'(MUX_PHASES - 1)) ? '0 : phase_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = F_REF;
            F_REF:  state_next = F_NODE;
            F_NODE: state_next = F_PREP;
            F_PREP: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full   = 1'b1;
        q_push = 1'b0;
        case (state_reg)
            F_IDLE: full = 1'b0;
            F_PREP: q_push = !q_full;
            default: ;
        endcase
    end

    always_comb
    begin
        q_item.diff    = (ref_mv_reg > node_mv_reg) ? ref_mv_reg - node_mv_reg : '0;
        q_item.numer   = PROD_W'(node_mv_reg) * PROD_W'(series_reg);
        q_item.slot    = slot_reg;
        q_item.monitor = mon_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            phase_reg  <= '0;
            series_reg <= SERIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && scan_end)
                phase_reg <= phase_next;
            if (cfg_valid)
                series_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ref_raw_reg  <= ref_uv;
            node_raw_reg <= node_uv;
            mon_reg      <= monitor_index;
            slot_reg     <= {channel_index, phase_reg};
        end
        if (state_reg == F_REF)
            ref_mv_reg <= mv;
        if (state_reg == F_NODE)
            node_mv_reg <= mv;
    end

endmodule

>>> src/tdt_queue.sv
// Short FIFO of prepared items between front and back.
// Depends on tdt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "thermistor_divider_to_temperature_defines.svh"

module tdt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tdt_pkg::tdt_item_t  wr_item,
    input  logic                pop,
    output logic                empty,
    output tdt_pkg::tdt_item_t  rd_item
);
    import tdt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tdt_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

    `TDT_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH))
    `TDT_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `TDT_ASSERT_IMPLIES(a_ptrs_meet, empty || full, wr_ptr_reg == rd_ptr_reg)

endmodule

>>> src/tdt_back.sv
// Back end: clamp checks, binary table search, interpolation divide, result register.
// Depends on tdt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "thermistor_divider_to_temperature_defines.svh"

module tdt_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  tdt_pkg::tdt_item_t           q_item,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [tdt_pkg::TEMP_W-1:0] temperature_q8,
    output logic [tdt_pkg::SLOT_W-1:0]   slot_index,
    output logic [tdt_pkg::MON_W-1:0]    monitor_out,
    output logic [tdt_pkg::FLAG_W-1:0]   range_flag
);
    import tdt_pkg::*;

    localparam int REM_W = PROD_W + 1;
    localparam int CNT_W = $clog2(FRAC_W);

    back_state_t        state_reg, state_next;
    tdt_item_t          item_reg;
    logic [IDX_W-1:0]   lo_reg, hi_reg, mid;
    logic [PROD_W-1:0]  rem_reg, den_reg;
    logic [FRAC_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TEMP_W-1:0]  temp_reg;
    range_t             flag_reg;
    logic               out_valid_reg;
    logic               load_item, load_out;

    logic [15:0]        tab_val;
    logic [PROD_W-1:0]  tab_prod;
    logic [IDX_W-1:0]   lo_prev;
    logic [15:0]        step;
    logic [REM_W-1:0]   rem_dbl;
    logic               rem_ge;
    logic               below_mid;
    logic               cold_hit, hot_hit;
    logic [TEMP_W-1:0]  interp_temp;

    assign lo_prev = lo_reg - 1'b1;
    assign mid     = IDX_W'((IDX_W + 1)'(lo_reg) + (IDX_W + 1)'(hi_reg) >> 1);

    // table read mux and single multiplier, operands selected by state
    always_comb
    begin
        case (state_reg)
            B_COLD:   tab_val = NTC_OHMS[0];
            B_HOT:    tab_val = NTC_OHMS[NTC_ENTRIES - 1];
            B_SEARCH: tab_val = NTC_OHMS[mid];
            default:  tab_val = NTC_OHMS[lo_prev];
        endcase
    end
    assign step     = NTC_OHMS[lo_prev] - NTC_OHMS[lo_reg];
    assign tab_prod = PROD_W'(item_reg.diff) *
                      PROD_W'((state_reg == B_DEN) ? step : tab_val);

    assign cold_hit  = (item_reg.diff == '0) || (item_reg.numer >= tab_prod);
    assign hot_hit   = (item_reg.numer <= tab_prod);
    assign below_mid = (tab_prod < item_reg.numer);

    // restoring division step
    assign rem_dbl   = {rem_reg, 1'b0};
    assign rem_ge    = (rem_dbl >= REM_W'(den_reg));
    assign quot_next = {quot_reg[FRAC_W-2:0], rem_ge};
    assign interp_temp = ((TEMP_W'(lo_reg) - IDX_OFFSET) << FRAC_W) + TEMP_W'(quot_next);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (!q_empty) state_next = B_COLD;
            B_COLD:   state_next = cold_hit ? B_WRITE : B_HOT;
            B_HOT:    state_next = hot_hit ? B_WRITE : B_SEARCH;
            B_SEARCH: if (lo_reg == hi_reg) state_next = B_NUM;
            B_NUM:    state_next = B_DEN;
            B_DEN:    state_next = B_DIV;
            B_DIV:    if (cnt_reg == CNT_W'(FRAC_W - 1)) state_next = B_WRITE;
            B_WRITE:  if (!out_valid_reg || pop) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        load_item = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            B_IDLE:  load_item = !q_empty;
            B_WRITE: load_out  = !out_valid_reg || pop;
            default: ;
        endcase
    end
    assign q_pop = load_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (load_item)
                    item_reg <= q_item;
            end
            B_COLD:
            begin
                temp_reg <= TEMP_COLD;
                flag_reg <= RANGE_COLD;
            end
            B_HOT:
            begin
                temp_reg <= TEMP_HOT;
                flag_reg <= RANGE_HOT;
                lo_reg   <= IDX_FIRST;
                hi_reg   <= IDX_LAST;
            end
            B_SEARCH:
            begin
                if (lo_reg != hi_reg)
                begin
                    if (below_mid)
                        hi_reg <= mid;
                    else
                        lo_reg <= mid + 1'b1;
                end
            end
            B_NUM:
            begin
                rem_reg <= tab_prod - item_reg.numer;
            end
            B_DEN:
            begin
                den_reg  <= tab_prod;
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            B_DIV:
            begin
                rem_reg  <= rem_ge ? PROD_W'(rem_dbl - REM_W'(den_reg)) : PROD_W'(rem_dbl);
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg + 1'b1;
                temp_reg <= interp_temp;
                flag_reg <= RANGE_IN;
            end
            B_WRITE:
            begin
                if (load_out)
                begin
                    temperature_q8 <= temp_reg;
                    slot_index     <= item_reg.slot;
                    monitor_out    <= item_reg.monitor;
                    range_flag     <= flag_reg;
                end
            end
            default: ;
        endcase
    end

    assign empty = !out_valid_reg;

    `TDT_ASSERT_IMPLIES(a_search_order, state_reg == B_SEARCH, lo_reg <= hi_reg)
    `TDT_ASSERT_IMPLIES(a_div_nonzero, state_reg == B_DIV, den_reg != '0)
    `TDT_ASSERT_IMPLIES(a_rem_below_den, state_reg == B_DIV, rem_reg < den_reg)
    `TDT_ASSERT_IMPLIES(a_pop_only_idle, q_pop, state_reg == B_IDLE)

endmodule

>>> src/thermistor_divider_to_temperature.sv
// Top level of the NTC thermistor divider to temperature converter.
// Depends on tdt_pkg, tdt_front, tdt_queue and tdt_back.
`timescale 1ns / 1ps

// Channel    Handshake            Payload
// input      push / full          ref_uv, node_uv, monitor_index, channel_index, scan_end
// result     pop / empty          temperature_q8, slot_index, monitor_out, range_flag
// config     cfg_valid/cfg_ready  cfg_data (series resistance, ohms)
//
// Front: accept, ref scaling, node scaling, prepare (held while the queue is full),
// then idle again before the next item. Back: cold check, hot check, bracket search,
// numerator, denominator, fraction divide, write (a clamp hit goes straight to write),
// then idle again before the next; it sets the sustained rate. A 2-entry queue sits between.
// Reset (rst_n low, async) clears FSMs, queue, mux phase and sets 10000 ohms.
// A held result stalls the back end at its write; the front keeps filling the queue.

module thermistor_divider_to_temperature #(
    parameter int MUX_PHASES = tdt_pkg::MUX_PHASES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         push,
    output logic                         full,
    input  logic [tdt_pkg::UV_W-1:0]     ref_uv,
    input  logic [tdt_pkg::UV_W-1:0]     node_uv,
    input  logic [tdt_pkg::MON_W-1:0]    monitor_index,
    input  logic [tdt_pkg::CHAN_W-1:0]   channel_index,
    input  logic                         scan_end,
    // results
    output logic                         empty,
    input  logic                         pop,
    output logic signed [tdt_pkg::TEMP_W-1:0] temperature_q8,
    output logic [tdt_pkg::SLOT_W-1:0]   slot_index,
    output logic [tdt_pkg::MON_W-1:0]    monitor_out,
    output logic [tdt_pkg::FLAG_W-1:0]   range_flag,
    // series resistance register
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tdt_pkg::SER_W-1:0]    cfg_data
);
    import tdt_pkg::*;

    tdt_item_t  fq_item, qb_item;
    logic       fq_push, fq_full;
    logic       qb_pop, qb_empty;

    // register write always taken; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    // front: mV scaling (reciprocal multiply), diff clamp, numerator product,
    // slot tagging and mux phase advance on scan end
    tdt_front #(
        .MUX_PHASES (MUX_PHASES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .ref_uv        (ref_uv),
        .node_uv       (node_uv),
        .monitor_index (monitor_index),
        .channel_index (channel_index),
        .scan_end      (scan_end),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .q_push        (fq_push),
        .q_full        (fq_full),
        .q_item        (fq_item)
    );

    // decoupling queue
    tdt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .full    (fq_full),
        .wr_item (fq_item),
        .pop     (qb_pop),
        .empty   (qb_empty),
        .rd_item (qb_item)
    );

    // back: open/cold/hot clamps by cross-multiplication, table bracket search,
    // floor interpolation over segment i-1..i, result register
    tdt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (qb_empty),
        .q_pop          (qb_pop),
        .q_item         (qb_item),
        .empty          (empty),
        .pop            (pop),
        .temperature_q8 (temperature_q8),
        .slot_index     (slot_index),
        .monitor_out    (monitor_out),
        .range_flag     (range_flag)
    );

endmodule
